[rtl/core/run_length_byte_encoder_top_macros.svh]
// assertion macros used by the run-length encoder datapath
`ifndef RUN_LENGTH_BYTE_ENCODER_TOP_MACROS_SVH
`define RUN_LENGTH_BYTE_ENCODER_TOP_MACROS_SVH

// condition holds at every clock edge out of reset
`define RLBE_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("rlbe invariant violated");

// consequent holds in the same cycle as the antecedent
`define RLBE_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rlbe implication violated");

`endif

[rtl/core/rlbe_pkg.sv]
// types and constants of the run-length byte encoder
package rlbe_pkg;

	localparam int LITERAL_MAX_DEF = 128;
	localparam int RUN_MAX = 130;
	localparam int RUN_MIN = 3;
	localparam logic [7:0] RUN_FLAG = 8'h80;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_SET,
		ST_RES,
		ST_APPEND,
		ST_RUN,
		ST_FLUSH_RD,
		ST_FLUSH_EMIT
	} rlbe_state_t;

	typedef enum logic [1:0] {
		RET_RUN,
		RET_APPEND,
		RET_END
	} rlbe_ret_t;

	typedef struct packed {
		logic capture;
		logic set_cand;
		logic app;
		logic run_emit;
		logic flush_rd;
		logic flush_emit;
		logic emit_done;
	} rlbe_cmd_t;

	typedef struct packed {
		logic need_resolve;
		logic cc_zero;
		logic cc_one;
		logic cc_ge3;
		logic lit_zero;
		logic lit_full;
		logic last_row;
		logic out_free;
		logic last_item;
	} rlbe_status_t;

endpackage

[rtl/core/rlbe_ctrl.sv]
// controller state machine of the run-length byte encoder
module rlbe_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  rlbe_pkg::rlbe_status_t st,
	output rlbe_pkg::rlbe_cmd_t    cmd
);
	import rlbe_pkg::*;

	rlbe_state_t state_q, state_d;
	rlbe_ret_t   ret_q, ret_d;
	logic        phase_q, phase_d;
	logic        final_q, final_d;

	function automatic rlbe_state_t resolve_exit(input logic last_phase, input logic lit_empty);
		rlbe_state_t s;
		if (!last_phase) begin
			s = ST_SET;
		end else if (!lit_empty) begin
			s = ST_FLUSH_RD;
		end else begin
			s = ST_IDLE;
		end
		return s;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= RET_END;
			phase_q <= 1'b0;
			final_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			phase_q <= phase_d;
			final_q <= final_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		phase_d = phase_q;
		final_d = final_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (st.need_resolve) begin
					phase_d = 1'b0;
					state_d = ST_RES;
				end else if (st.last_item) begin
					phase_d = 1'b1;
					state_d = ST_RES;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SET: begin
				if (st.last_item) begin
					phase_d = 1'b1;
					state_d = ST_RES;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_RES: begin
				if (st.cc_ge3) begin
					if (st.lit_zero) begin
						state_d = ST_RUN;
					end else begin
						ret_d   = RET_RUN;
						final_d = 1'b0;
						state_d = ST_FLUSH_RD;
					end
				end else begin
					state_d = ST_APPEND;
				end
			end
			ST_APPEND: begin
				if (st.lit_full) begin
					ret_d   = RET_APPEND;
					final_d = phase_q && st.cc_one;
					state_d = ST_FLUSH_RD;
				end else if (st.cc_one) begin
					ret_d   = RET_END;
					final_d = 1'b1;
					state_d = resolve_exit(phase_q, 1'b0);
				end
			end
			ST_RUN: begin
				if (st.out_free) begin
					ret_d   = RET_END;
					final_d = 1'b1;
					state_d = resolve_exit(phase_q, 1'b1);
				end
			end
			ST_FLUSH_RD: begin
				state_d = ST_FLUSH_EMIT;
			end
			ST_FLUSH_EMIT: begin
				if (st.out_free) begin
					if (!st.last_row) begin
						state_d = ST_FLUSH_RD;
					end else begin
						case (ret_q)
							RET_RUN: begin
								state_d = ST_RUN;
							end
							RET_APPEND: begin
								if (st.cc_zero) begin
									ret_d   = RET_END;
									final_d = 1'b1;
									state_d = resolve_exit(phase_q, 1'b1);
								end else begin
									state_d = ST_APPEND;
								end
							end
							default: begin
								state_d = ST_IDLE;
							end
						endcase
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		in_ready       = 1'b0;
		cmd            = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_EVAL: begin
				cmd.set_cand = !st.need_resolve;
			end
			ST_SET: begin
				cmd.set_cand = 1'b1;
			end
			ST_APPEND: begin
				cmd.app = 1'b1;
			end
			ST_RUN: begin
				cmd.run_emit  = st.out_free;
				cmd.emit_done = phase_q;
			end
			ST_FLUSH_RD: begin
				cmd.flush_rd = 1'b1;
			end
			ST_FLUSH_EMIT: begin
				cmd.flush_emit = st.out_free;
				cmd.emit_done  = final_q && st.last_row;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

[rtl/core/rlbe_datapath.sv]
// datapath of the run-length byte encoder: run tracking, literal store, output word
`include "run_length_byte_encoder_top_macros.svh"

module rlbe_datapath #(
	parameter int LITERAL_MAX = rlbe_pkg::LITERAL_MAX_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [7:0]             data_byte,
	input  logic                   end_of_block,
	input  rlbe_pkg::rlbe_cmd_t    cmd,
	output rlbe_pkg::rlbe_status_t st,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [7:0]             out_byte0,
	output logic [7:0]             out_byte1,
	output logic [7:0]             out_byte2,
	output logic [7:0]             out_byte3,
	output logic [2:0]             byte_count,
	output logic                   block_done
);
	import rlbe_pkg::*;

	localparam int LIT_ROWS = LITERAL_MAX / 4 + 1;
	localparam int RW = (LIT_ROWS > 1) ? $clog2(LIT_ROWS) : 1;
	localparam int LW = $clog2(LITERAL_MAX + 1);
	localparam int TW = $clog2(LITERAL_MAX + 6);

	logic [7:0]      b_q;
	logic            last_q;
	logic [7:0]      cb_q;
	logic [7:0]      cc_q;
	logic [LW-1:0]   lit_cnt_q;
	logic [RW-1:0]   row_q;
	logic [3:0][7:0] mem_q [LIT_ROWS];
	logic [3:0][7:0] rd_q;

	logic            out_valid_q;
	logic [3:0][7:0] out_bytes_q;
	logic [2:0]      out_cnt_q;
	logic            out_done_q;

	logic [LW-1:0]   wr_pos;
	logic [RW-1:0]   wr_row;
	logic [1:0]      wr_lane;
	logic [TW-1:0]   total;
	logic [TW-1:0]   row_base;
	logic [TW-1:0]   rem;
	logic [2:0]      flush_cnt;
	logic [7:0]      header;
	logic [3:0][7:0] flush_word;
	logic            out_free;

	assign wr_pos   = lit_cnt_q + LW'(1);
	assign wr_row   = RW'(wr_pos >> 2);
	assign wr_lane  = wr_pos[1:0];
	assign total    = TW'(lit_cnt_q) + TW'(1);
	assign row_base = TW'({row_q, 2'b00});
	assign rem      = total - row_base;
	assign header   = 8'(lit_cnt_q - LW'(1));
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		flush_cnt = (rem <= TW'(4)) ? rem[2:0] : 3'd4;
		for (int j = 0; j < 4; j++) begin
			flush_word[j] = (3'(j) < flush_cnt) ? rd_q[j] : 8'h00;
		end
		if (row_q == '0) begin
			flush_word[0] = header;
		end
	end

	always_comb begin
		st.need_resolve = (cc_q != 8'd0) && ((b_q != cb_q) || (cc_q >= 8'(RUN_MAX)));
		st.cc_zero      = (cc_q == 8'd0);
		st.cc_one       = (cc_q == 8'd1);
		st.cc_ge3       = (cc_q >= 8'(RUN_MIN));
		st.lit_zero     = (lit_cnt_q == '0);
		st.lit_full     = (lit_cnt_q == LW'(LITERAL_MAX - 1));
		st.last_row     = (rem <= TW'(4));
		st.out_free     = out_free;
		st.last_item    = last_q;
	end

	// literal store
	always_ff @(posedge clk) begin
		if (cmd.app) begin
			mem_q[wr_row][wr_lane] <= cb_q;
		end
		if (cmd.flush_rd) begin
			rd_q <= mem_q[row_q];
		end
	end

	// input byte holding register
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			b_q    <= data_byte;
			last_q <= end_of_block;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cb_q      <= 8'd0;
			cc_q      <= 8'd0;
			lit_cnt_q <= '0;
			row_q     <= '0;
		end else begin
			if (cmd.set_cand) begin
				if (cc_q == 8'd0) begin
					cb_q <= b_q;
					cc_q <= 8'd1;
				end else begin
					cc_q <= cc_q + 8'd1;
				end
			end
			if (cmd.app) begin
				lit_cnt_q <= wr_pos;
				cc_q      <= cc_q - 8'd1;
			end
			if (cmd.run_emit) begin
				cc_q <= 8'd0;
			end
			if (cmd.flush_emit) begin
				if (st.last_row) begin
					row_q     <= '0;
					lit_cnt_q <= '0;
				end else begin
					row_q <= row_q + RW'(1);
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.run_emit || cmd.flush_emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.run_emit) begin
			out_bytes_q <= {8'h00, 8'h00, cb_q, RUN_FLAG | (cc_q - 8'(RUN_MIN))};
			out_cnt_q   <= 3'd2;
			out_done_q  <= cmd.emit_done;
		end else if (cmd.flush_emit) begin
			out_bytes_q <= flush_word;
			out_cnt_q   <= flush_cnt;
			out_done_q  <= cmd.emit_done;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte0  = out_bytes_q[0];
	assign out_byte1  = out_bytes_q[1];
	assign out_byte2  = out_bytes_q[2];
	assign out_byte3  = out_bytes_q[3];
	assign byte_count = out_cnt_q;
	assign block_done = out_done_q;

	`RLBE_ASSERT_IMPLY(a_load_when_free, cmd.run_emit || cmd.flush_emit, out_free)
	`RLBE_ASSERT_IMPLY(a_run_after_flush, cmd.run_emit, lit_cnt_q == '0)
	`RLBE_ASSERT_IMPLY(a_append_has_run, cmd.app, cc_q != 8'd0)
	`RLBE_ASSERT_ALWAYS(a_run_bound, cc_q <= 8'(RUN_MAX))

endmodule

[rtl/core/run_length_byte_encoder_top.sv]
// top level of the run-length byte encoder
// Usage:
//   Input channel (in_valid/in_ready) carries one raw byte per transfer in
//   data_byte, with end_of_block set on the final byte of a block.
//   Output channel (out_valid/out_ready) carries coded words of up to four
//   bytes, out_byte0 first, byte_count valid bytes, unused bytes zero.
//   block_done marks the final word of a coded block.
//   A byte that extends a pending run is transferred and then evaluated.
//   A run code word is loaded into the output register via the evaluate,
//   resolve and run states after the transfer of the byte that ends the run
//   when no literals are pending; pending literals go out first. A literal
//   chunk is read from the literal store one row of four bytes at a time, each
//   row read and then emitted, up to 33 words for a full buffer; the store has
//   a single read port. The input is not ready while a chunk or run is coded.
//   At reset the run and literal state are empty and no word is pending.
//   When the receiver stalls, the finished word waits in the output register
//   and the controller holds until it is taken; input is still accepted
//   while a word waits, as long as no further word has to be produced.
module run_length_byte_encoder_top #(
	parameter int LITERAL_MAX = rlbe_pkg::LITERAL_MAX_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       end_of_block,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte0,
	output logic [7:0] out_byte1,
	output logic [7:0] out_byte2,
	output logic [7:0] out_byte3,
	output logic [2:0] byte_count,
	output logic       block_done
);
	import rlbe_pkg::*;

	rlbe_cmd_t    cmd;
	rlbe_status_t st;

	rlbe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	rlbe_datapath #(
		.LITERAL_MAX (LITERAL_MAX)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_byte    (data_byte),
		.end_of_block (end_of_block),
		.cmd          (cmd),
		.st           (st),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte0    (out_byte0),
		.out_byte1    (out_byte1),
		.out_byte2    (out_byte2),
		.out_byte3    (out_byte3),
		.byte_count   (byte_count),
		.block_done   (block_done)
	);

endmodule
